FILE: hdl/triangle_tile_coverage_defines.svh
// Assertion macros for the triangle tile coverage checker.
`ifndef TRIANGLE_TILE_COVERAGE_DEFINES_SVH
`define TRIANGLE_TILE_COVERAGE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TTC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle_tile_coverage: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TTC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle_tile_coverage: next-cycle check failed");

`endif

FILE: hdl/ttc_pkg.sv
// Package: widths, types and helpers of the triangle tile coverage block.
`default_nettype none

package ttc_pkg;

    localparam int TILE_SIZE  = 32;
    localparam int COORD_BITS = 12;

    // fixed field widths
    localparam int IN_W    = 12;
    localparam int IDX_W   = 7;
    localparam int ROWY_W  = 12;
    localparam int MASK_W  = 32;
    localparam int EDGE_W  = 26;

    localparam int MASK_COLS = (TILE_SIZE < MASK_W) ? TILE_SIZE : MASK_W;
    localparam int ROW_LIMIT = (TILE_SIZE < MASK_W) ? TILE_SIZE : MASK_W;

    // internal widths
    localparam int CW = COORD_BITS;
    localparam int TW = IDX_W + $clog2(TILE_SIZE);   // tile left/top/bottom
    localparam int RW = (TW > CW) ? TW : CW;         // unsigned row/column range
    localparam int DW = RW + 1;                      // signed differences
    localparam int PW = 2 * DW;                      // products
    localparam int EW = 2 * DW + 1;                  // edge values

    localparam int QDEPTH = 2;
    localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    typedef logic [IN_W-1:0]          in_coord_t;
    typedef logic [IDX_W-1:0]         tile_idx_t;
    typedef logic [CW-1:0]            coord_t;
    typedef logic [RW-1:0]            yrange_t;
    typedef logic signed [DW-1:0]     diff_t;
    typedef logic signed [PW-1:0]     prod_t;
    typedef logic signed [EW-1:0]     edge_t;
    typedef logic [ROWY_W-1:0]        rowy_t;
    typedef logic [MASK_W-1:0]        mask_t;
    typedef logic signed [EDGE_W-1:0] edge_out_t;
    typedef logic [QPW-1:0]           qptr_t;
    typedef logic [QPW:0]             qcnt_t;

    // one triangle ready for the row walk
    typedef struct packed {
        edge_t  e_a;
        edge_t  e_b;
        edge_t  e_c;
        diff_t  sx_a;
        diff_t  sx_b;
        diff_t  sx_c;
        diff_t  sy_a;
        diff_t  sy_b;
        diff_t  sy_c;
        coord_t cur_row;
        coord_t end_row;
        edge_t  area;
    } tri_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic diff_t sub_d(yrange_t a, yrange_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ttc_front.sv
// Front end: takes a triangle, forms edge setup, culls, and queues the walk record.
`default_nettype none

module ttc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ttc_pkg::in_coord_t  vertex0_x,
    input  wire ttc_pkg::in_coord_t  vertex0_y,
    input  wire ttc_pkg::in_coord_t  vertex1_x,
    input  wire ttc_pkg::in_coord_t  vertex1_y,
    input  wire ttc_pkg::in_coord_t  vertex2_x,
    input  wire ttc_pkg::in_coord_t  vertex2_y,
    input  wire ttc_pkg::tile_idx_t  tile_col,
    input  wire ttc_pkg::tile_idx_t  tile_row,
    input  wire ttc_pkg::q_stat_t    q_stat,
    output logic                     q_push,
    output ttc_pkg::tri_rec_t        q_rec
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;

    ttc_pkg::yrange_t x0, y0, x1, y1, x2, y2;
    ttc_pkg::yrange_t left, top, bottom, ymax, ymin, cur, fin, span, fin_c;
    logic             accept, cull;

    // setup registers (held until the next accepted item)
    ttc_pkg::diff_t  ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    ttc_pkg::diff_t  dxl0_reg, dxl1_reg, dxl2_reg, dyr0_reg, dyr1_reg, dyr2_reg;
    ttc_pkg::coord_t cur_reg, fin_reg;
    logic            empty_reg;

    // products
    ttc_pkg::prod_t pa0_reg, pa1_reg;
    ttc_pkg::prod_t pe0a_reg, pe0b_reg, pe1a_reg, pe1b_reg, pe2a_reg, pe2b_reg;

    ttc_pkg::edge_t area;

    assign in_stall = (state_reg != F_IDLE);
    assign accept   = in_valid && (state_reg == F_IDLE);

    always_comb
    begin
        x0     = ttc_pkg::yrange_t'(ttc_pkg::coord_t'(vertex0_x));
        y0     = ttc_pkg::yrange_t'(ttc_pkg::coord_t'(vertex0_y));
        x1     = ttc_pkg::yrange_t'(ttc_pkg::coord_t'(vertex1_x));
        y1     = ttc_pkg::yrange_t'(ttc_pkg::coord_t'(vertex1_y));
        x2     = ttc_pkg::yrange_t'(ttc_pkg::coord_t'(vertex2_x));
        y2     = ttc_pkg::yrange_t'(ttc_pkg::coord_t'(vertex2_y));
        left   = ttc_pkg::yrange_t'(tile_col) * ttc_pkg::yrange_t'(ttc_pkg::TILE_SIZE);
        top    = ttc_pkg::yrange_t'(tile_row) * ttc_pkg::yrange_t'(ttc_pkg::TILE_SIZE);
        bottom = top + ttc_pkg::yrange_t'(ttc_pkg::TILE_SIZE - 1);
        ymax   = (y0 > y1) ? y0 : y1;
        ymax   = (y2 > ymax) ? y2 : ymax;
        ymin   = (y0 < y1) ? y0 : y1;
        ymin   = (y2 < ymin) ? y2 : ymin;
        cur    = (ymax < bottom) ? ymax : bottom;
        fin    = (ymin > top) ? ymin : top;
        span   = cur - fin;
        // more rows than the walk allows: keep the bottom ROW_LIMIT rows
        fin_c  = (span >= ttc_pkg::yrange_t'(ttc_pkg::ROW_LIMIT))
                 ? cur - ttc_pkg::yrange_t'(ttc_pkg::ROW_LIMIT - 1) : fin;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg    <= ttc_pkg::sub_d(x0, x2);
            ay_reg    <= ttc_pkg::sub_d(y0, y2);
            bx_reg    <= ttc_pkg::sub_d(x1, x0);
            by_reg    <= ttc_pkg::sub_d(y1, y0);
            cx_reg    <= ttc_pkg::sub_d(x2, x1);
            cy_reg    <= ttc_pkg::sub_d(y2, y1);
            dxl0_reg  <= ttc_pkg::sub_d(left, x0);
            dxl1_reg  <= ttc_pkg::sub_d(left, x1);
            dxl2_reg  <= ttc_pkg::sub_d(left, x2);
            dyr0_reg  <= ttc_pkg::sub_d(cur, y0);
            dyr1_reg  <= ttc_pkg::sub_d(cur, y1);
            dyr2_reg  <= ttc_pkg::sub_d(cur, y2);
            cur_reg   <= ttc_pkg::coord_t'(cur);
            fin_reg   <= ttc_pkg::coord_t'(fin_c);
            empty_reg <= (cur < fin);
        end
        if (state_reg == F_MUL)
        begin
            pa0_reg  <= ttc_pkg::prod_t'(bx_reg) * ttc_pkg::prod_t'(ay_reg);
            pa1_reg  <= ttc_pkg::prod_t'(by_reg) * ttc_pkg::prod_t'(ax_reg);
            pe0a_reg <= ttc_pkg::prod_t'(dxl0_reg) * ttc_pkg::prod_t'(ay_reg);
            pe0b_reg <= ttc_pkg::prod_t'(dyr0_reg) * ttc_pkg::prod_t'(ax_reg);
            pe1a_reg <= ttc_pkg::prod_t'(dxl1_reg) * ttc_pkg::prod_t'(by_reg);
            pe1b_reg <= ttc_pkg::prod_t'(dyr1_reg) * ttc_pkg::prod_t'(bx_reg);
            pe2a_reg <= ttc_pkg::prod_t'(dxl2_reg) * ttc_pkg::prod_t'(cy_reg);
            pe2b_reg <= ttc_pkg::prod_t'(dyr2_reg) * ttc_pkg::prod_t'(cx_reg);
        end
    end

    always_comb
    begin
        area          = ttc_pkg::edge_t'(pa0_reg) - ttc_pkg::edge_t'(pa1_reg);
        cull          = !area[ttc_pkg::EW-1] || empty_reg;
        q_rec.e_a     = ttc_pkg::edge_t'(pe0a_reg) - ttc_pkg::edge_t'(pe0b_reg);
        q_rec.e_b     = ttc_pkg::edge_t'(pe1a_reg) - ttc_pkg::edge_t'(pe1b_reg);
        q_rec.e_c     = ttc_pkg::edge_t'(pe2a_reg) - ttc_pkg::edge_t'(pe2b_reg);
        q_rec.sx_a    = ay_reg;
        q_rec.sx_b    = by_reg;
        q_rec.sx_c    = cy_reg;
        q_rec.sy_a    = ax_reg;
        q_rec.sy_b    = bx_reg;
        q_rec.sy_c    = cx_reg;
        q_rec.cur_row = cur_reg;
        q_rec.end_row = fin_reg;
        q_rec.area    = area;
        q_push        = (state_reg == F_PUSH) && !cull && !q_stat.full;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (cull || !q_stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ttc_queue.sv
// Short queue of walk records between the front end and the row walker.
`default_nettype none

module ttc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ttc_pkg::tri_rec_t push_rec,
    input  wire logic              pop,
    output ttc_pkg::tri_rec_t      head_rec,
    output ttc_pkg::q_stat_t       stat
);

    ttc_pkg::tri_rec_t mem_reg [ttc_pkg::QDEPTH];
    ttc_pkg::qptr_t    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    ttc_pkg::qcnt_t    cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign stat.full  = (cnt_reg == ttc_pkg::qcnt_t'(ttc_pkg::QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ttc_pkg::qptr_t'(ttc_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ttc_pkg::qptr_t'(ttc_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ttc_back.sv
// Row walker: one coverage row per unstalled cycle into the output register.
`default_nettype none

module ttc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ttc_pkg::q_stat_t  q_stat,
    input  wire ttc_pkg::tri_rec_t q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ttc_pkg::rowy_t         row_y,
    output ttc_pkg::mask_t         coverage_mask,
    output ttc_pkg::edge_out_t     edge_a_left,
    output ttc_pkg::edge_out_t     edge_b_left,
    output ttc_pkg::edge_out_t     edge_c_left,
    output ttc_pkg::edge_out_t     signed_area,
    output logic                   last_row
);

    ttc_pkg::tri_rec_t walk_reg, walk_next;
    logic              busy_reg, busy_next;
    logic              ov_reg, ov_next;
    logic              out_adv, emit, is_last;
    ttc_pkg::mask_t    mask;

    ttc_pkg::rowy_t     row_y_reg;
    ttc_pkg::mask_t     mask_reg;
    ttc_pkg::edge_out_t ea_reg, eb_reg, ec_reg, area_reg;
    logic               last_reg;

    assign out_adv = !ov_reg || !out_stall;
    assign q_pop   = !busy_reg && !q_stat.empty;
    assign emit    = busy_reg && out_adv;
    assign is_last = (walk_reg.cur_row == walk_reg.end_row);

    // per-column lanes: value at column i is left value plus i times x step
    always_comb
    begin
        ttc_pkg::edge_t va, vb, vc;
        mask = '0;
        for (int i = 0; i < ttc_pkg::MASK_COLS; i++)
        begin
            va = walk_reg.e_a + ttc_pkg::edge_t'(i) * ttc_pkg::edge_t'(walk_reg.sx_a);
            vb = walk_reg.e_b + ttc_pkg::edge_t'(i) * ttc_pkg::edge_t'(walk_reg.sx_b);
            vc = walk_reg.e_c + ttc_pkg::edge_t'(i) * ttc_pkg::edge_t'(walk_reg.sx_c);
            mask[i] = (va <= 0) && (vb <= 0) && (vc <= 0);
        end
    end

    always_comb
    begin
        walk_next = walk_reg;
        busy_next = busy_reg;
        ov_next   = ov_reg;
        if (out_adv)
        begin
            ov_next = emit;
        end
        if (q_pop)
        begin
            walk_next = q_head;
            busy_next = 1'b1;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                walk_next.e_a     = walk_reg.e_a + ttc_pkg::edge_t'(walk_reg.sy_a);
                walk_next.e_b     = walk_reg.e_b + ttc_pkg::edge_t'(walk_reg.sy_b);
                walk_next.e_c     = walk_reg.e_c + ttc_pkg::edge_t'(walk_reg.sy_c);
                walk_next.cur_row = walk_reg.cur_row - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;
        if (emit)
        begin
            row_y_reg <= ttc_pkg::rowy_t'(walk_reg.cur_row);
            mask_reg  <= mask;
            ea_reg    <= ttc_pkg::edge_out_t'(walk_reg.e_a);
            eb_reg    <= ttc_pkg::edge_out_t'(walk_reg.e_b);
            ec_reg    <= ttc_pkg::edge_out_t'(walk_reg.e_c);
            area_reg  <= ttc_pkg::edge_out_t'(walk_reg.area);
            last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    assign out_valid     = ov_reg;
    assign row_y         = row_y_reg;
    assign coverage_mask = mask_reg;
    assign edge_a_left   = ea_reg;
    assign edge_b_left   = eb_reg;
    assign edge_c_left   = ec_reg;
    assign signed_area   = area_reg;
    assign last_row      = last_reg;

endmodule

`default_nettype wire

FILE: hdl/triangle_tile_coverage.sv
// Top level: triangle against one tile, one coverage row result per walked row.
//
//   channel   direction   handshake              payload
//   in        sink        in_valid / in_stall    three vertices, tile_col, tile_row
//   out       source      out_valid / out_stall  row_y, coverage_mask, edge values,
//                                                signed_area, last_row
//
// Steps: the front end accepts a triangle, forms eight 13x13 products, then
// does the area check and queue write; it takes no new triangle until done.
// The row walker loads a record, then walks its 1 to 32 rows, one row per
// cycle while not stalled, and loads the next record only after the last row.
// Culled triangles and triangles with no rows in the tile leave nothing.
// Reset (rst_n low) clears the front state, the queue pointers and the
// walker's busy and valid flags; no clearing pass follows.
// A held out_stall freezes the output register and the walker; the
// two-entry queue keeps the front end working until it fills, then
// in_stall stays high.
`default_nettype none

module triangle_tile_coverage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ttc_pkg::in_coord_t  vertex0_x,
    input  wire ttc_pkg::in_coord_t  vertex0_y,
    input  wire ttc_pkg::in_coord_t  vertex1_x,
    input  wire ttc_pkg::in_coord_t  vertex1_y,
    input  wire ttc_pkg::in_coord_t  vertex2_x,
    input  wire ttc_pkg::in_coord_t  vertex2_y,
    input  wire ttc_pkg::tile_idx_t  tile_col,
    input  wire ttc_pkg::tile_idx_t  tile_row,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ttc_pkg::rowy_t           row_y,
    output ttc_pkg::mask_t           coverage_mask,
    output ttc_pkg::edge_out_t       edge_a_left,
    output ttc_pkg::edge_out_t       edge_b_left,
    output ttc_pkg::edge_out_t       edge_c_left,
    output ttc_pkg::edge_out_t       signed_area,
    output logic                     last_row
);

    // front end -> queue
    logic              q_push;
    ttc_pkg::tri_rec_t q_rec;

    // queue -> row walker
    logic              q_pop;
    ttc_pkg::tri_rec_t q_head;
    ttc_pkg::q_stat_t  q_stat;

    // setup, area cull and row range
    ttc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .vertex0_x (vertex0_x),
        .vertex0_y (vertex0_y),
        .vertex1_x (vertex1_x),
        .vertex1_y (vertex1_y),
        .vertex2_x (vertex2_x),
        .vertex2_y (vertex2_y),
        .tile_col  (tile_col),
        .tile_row  (tile_row),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_rec     (q_rec)
    );

    // decouples setup from the row walk
    ttc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_rec),
        .pop      (q_pop),
        .head_rec (q_head),
        .stat     (q_stat)
    );

    // row walk: edge values step by the x deltas for each row up
    ttc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_y         (row_y),
        .coverage_mask (coverage_mask),
        .edge_a_left   (edge_a_left),
        .edge_b_left   (edge_b_left),
        .edge_c_left   (edge_c_left),
        .signed_area   (signed_area),
        .last_row      (last_row)
    );

endmodule

`default_nettype wire

FILE: hdl/ttc_checker.sv
// Port checker for the triangle tile coverage block, with its bind.
`default_nettype none

`include "triangle_tile_coverage_defines.svh"

module ttc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire ttc_pkg::rowy_t     row_y,
    input wire ttc_pkg::mask_t     coverage_mask,
    input wire ttc_pkg::edge_out_t edge_a_left,
    input wire ttc_pkg::edge_out_t edge_b_left,
    input wire ttc_pkg::edge_out_t edge_c_left,
    input wire ttc_pkg::edge_out_t signed_area,
    input wire logic               last_row
);

    // a held result keeps its payload
    `TTC_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(row_y) && $stable(coverage_mask) && $stable(last_row)
        && $stable(edge_a_left) && $stable(edge_b_left) && $stable(edge_c_left)
        && $stable(signed_area))

    // rows of one triangle come back to back, one row up each time
    `TTC_ASSERT_NXT(a_row_walk, out_valid && !out_stall && !last_row,
        out_valid && (row_y == ttc_pkg::rowy_t'($past(row_y) - 1'b1))
        && (signed_area == $past(signed_area)))

    // only front-facing triangles produce rows
    `TTC_ASSERT_IMP(a_area_neg, out_valid, signed_area[ttc_pkg::EDGE_W-1])

    // the front end is busy right after taking an item
    `TTC_ASSERT_NXT(a_in_busy, in_valid && !in_stall, in_stall)

endmodule

bind triangle_tile_coverage ttc_checker u_ttc_checker (.*);

`default_nettype wire
